FILE: design/ffcr_pkg.sv
`timescale 1ns / 1ps

package ffcr_pkg;

   localparam int FRAME_BYTES_DEF = 8;
   localparam int FRAME_W_MAX     = 64;
   localparam int VERSION_W       = 4;
   localparam logic [VERSION_W-1:0] VERSION_RESET = 4'h1;
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   typedef enum logic [1:0] {
      STATUS_BUSY    = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_VALID   = 2'd2
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [FRAME_W_MAX-1:0] frame;
   } result_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: design/ffcr_frame_asm.sv
`timescale 1ns / 1ps

module ffcr_frame_asm #(
   parameter int FRAME_BYTES = ffcr_pkg::FRAME_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ffcr_pkg::VERSION_W-1:0]      csr_write_data,
   input  logic                                beat_accept,
   input  logic [7:0]                          rx_byte,
   output ffcr_pkg::result_type                result
);
   import ffcr_pkg::*;

   localparam int CNT_W   = $clog2(FRAME_BYTES);
   localparam int STORE_W = (FRAME_BYTES - 1) * 8;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES - 1);

   logic [VERSION_W-1:0] version_ff, version_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [7:0]           crc_ff, crc_in;
   logic [STORE_W-1:0]   store_ff, store_in;
   logic [STORE_W+7:0]   shifted;
   logic                 start_hit;

   assign shifted   = {store_ff, rx_byte};
   assign start_hit = (rx_byte[7:4] == version_ff);
   assign version_in = csr_write_en ? csr_write_data : version_ff;

   always_comb begin
      count_in      = count_ff;
      crc_in        = crc_ff;
      store_in      = store_ff;
      result.status = STATUS_BUSY;
      result.frame  = '0;
      if (beat_accept) begin
         if (count_ff == '0) begin
            if (start_hit) begin
               store_in = STORE_W'(rx_byte);
               crc_in   = crc8_byte(CRC_INIT, rx_byte);
               count_in = CNT_W'(1);
            end
         end else if (count_ff < LAST_CNT) begin
            store_in = shifted[STORE_W-1:0];
            crc_in   = crc8_byte(crc_ff, rx_byte);
            count_in = count_ff + CNT_W'(1);
         end else begin
            // last beat: the byte itself is the CRC
            count_in = '0;
            crc_in   = CRC_INIT;
            if (crc_ff != rx_byte) begin
               result.status = STATUS_CRC_ERR;
            end else begin
               result.status = STATUS_VALID;
               result.frame  = FRAME_W_MAX'(shifted);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         count_ff   <= '0;
         crc_ff     <= CRC_INIT;
      end else begin
         version_ff <= version_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_CNT)
      else $error("frame byte count past last byte");

   a_idle_crc_clear: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> crc_ff == CRC_INIT)
      else $error("running crc not cleared while idle");

   a_ignore_stays_idle: assert property (@(posedge clock) disable iff (reset)
      beat_accept && count_ff == '0 && !start_hit |=> count_ff == '0)
      else $error("non-start byte left idle");

   a_result_on_last: assert property (@(posedge clock) disable iff (reset)
      result.status != STATUS_BUSY |-> beat_accept && count_ff == LAST_CNT)
      else $error("frame result outside last beat");

endmodule

FILE: design/ffcr_out_stage.sv
`timescale 1ns / 1ps

module ffcr_out_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   output logic                                 beat_accept,
   input  ffcr_pkg::result_type                 result,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [ffcr_pkg::FRAME_W_MAX-1:0]     rsp_frame
);
   import ffcr_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // every accepted beat yields one result, so the input waits only on a held result
   assign req_stall   = valid_ff & rsp_stall;
   assign beat_accept = req_valid & ~req_stall;

   assign valid_in  = beat_accept | (valid_ff & rsp_stall);
   assign result_in = beat_accept ? result : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = result_ff.status;
   assign rsp_frame  = result_ff.frame;

endmodule

FILE: design/fixed_frame_crc8_receiver.sv
`timescale 1ns / 1ps

// Fixed-length frame receiver with CRC-8 check (poly 0x07, init 0, MSB first).
// req_ channel: one received byte per beat (req_rx_byte). While idle, a byte
//   whose high nibble equals the version register starts a frame; others are
//   ignored. FRAME_BYTES bytes make a frame, the last being the CRC of the rest.
// rsp_ channel: exactly one result beat per input beat. rsp_status is busy
//   (0) for bytes inside a frame or ignored, crc error (1) or valid frame (2)
//   on the last byte; rsp_frame holds the frame right-aligned, first byte
//   highest, and is zero unless status is valid.
// csr_ port: csr_write_en writes the 4-bit version nibble; write only while idle.
// Each accepted byte's result passes through the single output register after
// the byte-wise CRC network; a byte can be accepted every cycle while
// req_stall is low.
// Reset (synchronous) returns to idle, clears the CRC, empties the output
// register and sets the version nibble to 1.
// When rsp_stall holds a pending result, req_stall rises in the same cycle and
// the input waits until the result is taken.
module fixed_frame_crc8_receiver #(
   parameter int FRAME_BYTES = ffcr_pkg::FRAME_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ffcr_pkg::VERSION_W-1:0]       csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [ffcr_pkg::FRAME_W_MAX-1:0]     rsp_frame
);
   import ffcr_pkg::*;

   logic       beat_accept;
   result_type result;

   ffcr_frame_asm #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_asm (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .beat_accept    (beat_accept),
      .rx_byte        (req_rx_byte),
      .result         (result)
   );

   ffcr_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .beat_accept (beat_accept),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_frame   (rsp_frame)
   );

endmodule
